// ===== hdl/frt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_pkg
// Shared item types, opcodes, status codes and a control struct for the
// fixed-height radix tree.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int NODE_BITS_MAX = 12;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EXISTS   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_NO_SPACE = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [23:0] key;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] found_value;
	} out_item_t;

	// free list stack control
	typedef struct packed {
		logic                     rd;
		logic                     pop;
		logic                     push;
		logic [NODE_BITS_MAX-1:0] node;
	} fs_ctl_t;

endpackage

// ===== hdl/frt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/frt_free_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_free_stack
// Stack of free node numbers with a count; an entry never pushed reads as
// its own index, so reset lists every node in order.
// ----------------------------------------------------------------------------
module frt_free_stack #(
	parameter int NODE_POOL = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  frt_pkg::fs_ctl_t                   ctl,
	output logic [$clog2(NODE_POOL)-1:0]       top,
	output logic [$clog2(NODE_POOL+1)-1:0]     count
);
	import frt_pkg::*;

	localparam int NW = $clog2(NODE_POOL);
	localparam int CW = $clog2(NODE_POOL+1);

	logic [CW-1:0]        count_q;
	logic [NODE_POOL-1:0] vld_q;
	logic                 vld_rd_q;
	logic [NW-1:0]        addr_rd_q;
	logic [NW-1:0]        raddr;
	logic [NW-1:0]        waddr;
	logic [NW-1:0]        rdata;

	assign raddr = NW'(count_q - CW'(1));
	assign waddr = NW'(count_q);

	frt_ram #(.WIDTH(NW), .DEPTH(NODE_POOL)) u_ram (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (waddr),
		.wdata (NW'(ctl.node)),
		.re    (ctl.rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(NODE_POOL);
			vld_q   <= '0;
		end else begin
			if (ctl.push) begin
				count_q      <= count_q + CW'(1);
				vld_q[waddr] <= 1'b1;
			end else if (ctl.pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			vld_rd_q  <= vld_q[raddr];
			addr_rd_q <= raddr;
		end
	end

	assign top   = vld_rd_q ? rdata : addr_rd_q;
	assign count = count_q;
endmodule

// ===== hdl/fixed_height_radix_tree.sv =====
`timescale 1ns / 1ps
// Steps: a lookup reads and checks each level walked (S_RD, S_CHK), then presents
//   the result in S_DONE; insert adds S_ALRD and S_ALWR per node allocated and
//   S_LEAF for the leaf write; delete adds an S_PRUNE check, plus S_PAR, S_PUP and
//   a recheck per pruned non-root node. A stalled output holds the last step.
// Throughput: one item at a time; a new item enters once the sequencer is
//   back in idle, while the previous result may still wait in the output.
// Reset: tree empty, all nodes free, tree_levels = 3; no clearing pass.
// ----------------------------------------------------------------------------
// fixed_height_radix_tree
// 64-way radix tree of fixed height over a node pool in RAM; lookup, insert
// and delete walked one level per step by a small sequencer.
// ----------------------------------------------------------------------------
module fixed_height_radix_tree #(
	parameter int DIGIT_BITS = 6,
	parameter int MAX_LEVELS = 4,
	parameter int NODE_POOL  = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  frt_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output frt_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_data
);
	import frt_pkg::*;

	localparam int FW     = DIGIT_BITS;
	localparam int FANOUT = 1 << FW;
	localparam int NW     = $clog2(NODE_POOL);
	localparam int CW     = $clog2(NODE_POOL+1);
	localparam int LW     = $clog2(MAX_LEVELS+1);
	localparam int SW     = (VALUE_BITS > NW) ? VALUE_BITS : NW;
	localparam int SA     = NW + FW;
	localparam logic [63:0] VMASK = (VALUE_BITS >= 64) ? ~64'd0
		: ((64'd1 << VALUE_BITS) - 64'd1);

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_ALRD  = 4'd3;
	localparam logic [3:0] S_ALWR  = 4'd4;
	localparam logic [3:0] S_LEAF  = 4'd5;
	localparam logic [3:0] S_PRUNE = 4'd6;
	localparam logic [3:0] S_PAR   = 4'd7;
	localparam logic [3:0] S_PUP   = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]        state_q;
	logic [2:0]        lv_cfg_q;
	logic              root_valid_q;
	logic [NW-1:0]     root_q;
	logic [1:0]        op_q;
	logic [23:0]       key_q;
	logic [31:0]       value_q;
	logic [LW-1:0]     l_q;
	logic [NW-1:0]     node_q;
	logic [FANOUT-1:0] word_q;
	logic [FW-1:0]     sip_q;
	logic              root_alloc_q;
	logic [1:0]        status_q;
	logic              found_q;
	logic [31:0]       fval_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [LW-1:0]     eff_lv;
	logic [FW-1:0]     dig;
	logic [63:0]       key_sh;
	logic [FANOUT-1:0] bitm;
	logic [FANOUT-1:0] sip_m;
	logic [FANOUT-1:0] pres_word;
	logic              hit;

	// memory ports
	logic              pres_we, pres_re;
	logic [NW-1:0]     pres_wa, pres_ra;
	logic [FANOUT-1:0] pres_wd, pres_rdata;
	logic [NODE_POOL-1:0] pv_q;
	logic              pv_rd_q;
	logic              slot_we, slot_re;
	logic [SW-1:0]     slot_wd, slot_rdata;
	logic              par_we, par_re;
	logic [NW-1:0]     par_wa;
	logic [SA-1:0]     par_wd, par_rdata;
	logic [NW-1:0]     par_up;
	fs_ctl_t           fs_ctl;
	logic [NW-1:0]     fs_top;
	logic [CW-1:0]     fs_count;
	logic [63:0]       val_ext;
	logic [63:0]       slot_ext;
	logic [LW-1:0]     l_next;

	// clamp the configured level count into 1..MAX_LEVELS
	always_comb begin
		if (lv_cfg_q == 3'd0) begin
			eff_lv = LW'(1);
		end else if (32'(lv_cfg_q) > MAX_LEVELS) begin
			eff_lv = LW'(MAX_LEVELS);
		end else begin
			eff_lv = LW'(lv_cfg_q);
		end
	end

	// digit for the current level; digits above the key read as zero
	assign key_sh    = {40'd0, key_q} >> ((32'(l_q) - 32'd1) * FW);
	assign dig       = key_sh[FW-1:0];
	assign bitm      = FANOUT'(1) << dig;
	assign sip_m     = FANOUT'(1) << sip_q;
	assign pres_word = pv_rd_q ? pres_rdata : '0;
	assign hit       = pres_word[dig];
	assign par_up    = par_rdata[SA-1:FW];
	assign val_ext   = 64'(value_q) & VMASK;
	assign slot_ext  = 64'(slot_rdata) & VMASK;
	assign l_next    = root_alloc_q ? l_q : (l_q - LW'(1));

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// memory controls per sequencer step
	always_comb begin
		pres_we = 1'b0; pres_re = 1'b0;
		pres_wa = node_q; pres_ra = node_q; pres_wd = word_q | bitm;
		slot_we = 1'b0; slot_re = 1'b0; slot_wd = SW'(val_ext);
		par_we  = 1'b0; par_re = 1'b0; par_wa = fs_top; par_wd = {node_q, dig};
		fs_ctl  = '0;
		fs_ctl.node = NODE_BITS_MAX'(node_q);
		unique case (state_q)
			S_RD: begin
				pres_re = 1'b1;
				slot_re = 1'b1;
			end
			S_CHK: begin
				if (op_q == OP_DELETE && l_q == LW'(1) && hit) begin
					pres_we = 1'b1;
					pres_wd = pres_word & ~bitm;
				end
			end
			S_ALRD: begin
				fs_ctl.rd = 1'b1;
			end
			S_ALWR: begin
				fs_ctl.pop = 1'b1;
				if (!root_alloc_q) begin
					pres_we = 1'b1;
					slot_we = 1'b1;
					slot_wd = SW'(fs_top);
					par_we  = 1'b1;
				end
			end
			S_LEAF: begin
				pres_we = 1'b1;
				slot_we = 1'b1;
			end
			S_PRUNE: begin
				if (word_q == '0) begin
					if (node_q == root_q) begin
						fs_ctl.push = 1'b1;
					end else begin
						par_re = 1'b1;
					end
				end
			end
			S_PAR: begin
				fs_ctl.push = 1'b1;
				pres_re     = 1'b1;
				pres_ra     = par_up;
			end
			S_PUP: begin
				pres_we = 1'b1;
				pres_wd = pres_word & ~sip_m;
			end
			default: begin
			end
		endcase
	end

	frt_ram #(.WIDTH(FANOUT), .DEPTH(NODE_POOL)) u_pres (
		.clk (clk), .we (pres_we), .waddr (pres_wa), .wdata (pres_wd),
		.re (pres_re), .raddr (pres_ra), .rdata (pres_rdata)
	);

	frt_ram #(.WIDTH(SW), .DEPTH(NODE_POOL * FANOUT)) u_slot (
		.clk (clk), .we (slot_we), .waddr ({node_q, dig}), .wdata (slot_wd),
		.re (slot_re), .raddr ({node_q, dig}), .rdata (slot_rdata)
	);

	frt_ram #(.WIDTH(SA), .DEPTH(NODE_POOL)) u_par (
		.clk (clk), .we (par_we), .waddr (par_wa), .wdata (par_wd),
		.re (par_re), .raddr (node_q), .rdata (par_rdata)
	);

	frt_free_stack #(.NODE_POOL(NODE_POOL)) u_free (
		.clk (clk), .arst_n (arst_n), .ctl (fs_ctl), .top (fs_top), .count (fs_count)
	);

	// present words are valid once written; an unwritten node reads empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
		end else if (pres_we) begin
			pv_q[pres_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pres_re) begin
			pv_rd_q <= pv_q[pres_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lv_cfg_q     <= 3'd3;
			root_valid_q <= 1'b0;
			root_q       <= '0;
			root_alloc_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the result once taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			// hold the level count while the tree holds anything
			if (cfg_we && !root_valid_q) begin
				lv_cfg_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_data.opcode;
						key_q    <= in_data.key;
						value_q  <= in_data.value;
						l_q      <= eff_lv;
						node_q   <= root_q;
						found_q  <= 1'b0;
						fval_q   <= '0;
						status_q <= ST_NOT_FOUND;
						if (in_data.opcode != OP_LOOKUP && in_data.opcode != OP_INSERT
							&& in_data.opcode != OP_DELETE) begin
							state_q <= S_DONE;
						end else if (root_valid_q) begin
							state_q <= S_RD;
						end else if (in_data.opcode != OP_INSERT) begin
							state_q <= S_DONE;
						end else if (32'(eff_lv) > 32'(fs_count)) begin
							status_q <= ST_NO_SPACE;
							state_q  <= S_DONE;
						end else begin
							root_alloc_q <= 1'b1;
							state_q      <= S_ALRD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					// a delete at the leaf keeps the word with its slot cleared
					word_q <= (op_q == OP_DELETE && l_q == LW'(1)) ? (pres_word & ~bitm)
						: pres_word;
					if (l_q != LW'(1)) begin
						if (hit) begin
							// advance to the child node
							node_q  <= slot_rdata[NW-1:0];
							l_q     <= l_q - LW'(1);
							state_q <= S_RD;
						end else if (op_q != OP_INSERT) begin
							state_q <= S_DONE;
						end else if (32'(l_q) - 32'd1 > 32'(fs_count)) begin
							status_q <= ST_NO_SPACE;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_ALRD;
						end
					end else begin
						unique case (op_q)
							OP_LOOKUP: begin
								if (hit) begin
									status_q <= ST_OK;
									found_q  <= 1'b1;
									fval_q   <= slot_ext[31:0];
								end
								state_q <= S_DONE;
							end
							OP_INSERT: begin
								if (hit) begin
									status_q <= ST_EXISTS;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_LEAF;
								end
							end
							default: begin
								if (hit) begin
									state_q <= S_PRUNE;
								end else begin
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				S_ALRD: begin
					state_q <= S_ALWR;
				end
				S_ALWR: begin
					// the fresh node starts empty
					node_q       <= fs_top;
					word_q       <= '0;
					l_q          <= l_next;
					root_alloc_q <= 1'b0;
					if (root_alloc_q) begin
						root_q       <= fs_top;
						root_valid_q <= 1'b1;
					end
					state_q <= (l_next != LW'(1)) ? S_ALRD : S_LEAF;
				end
				S_LEAF: begin
					status_q <= ST_OK;
					state_q  <= S_DONE;
				end
				S_PRUNE: begin
					if (word_q != '0) begin
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end else if (node_q == root_q) begin
						root_valid_q <= 1'b0;
						status_q     <= ST_OK;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_PAR;
					end
				end
				S_PAR: begin
					node_q  <= par_up;
					sip_q   <= par_rdata[FW-1:0];
					state_q <= S_PUP;
				end
				S_PUP: begin
					word_q  <= pres_word & ~sip_m;
					state_q <= S_PRUNE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_q.status      <= status_q;
			out_q.found       <= found_q;
			out_q.found_value <= fval_q;
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fs_ctl.pop |-> fs_count != '0)
		else $error("free list pop while empty");
	a_push_notfull: assert property (@(posedge clk) disable iff (!arst_n)
		fs_ctl.push |-> fs_count != CW'(NODE_POOL))
		else $error("free list push while full");
	a_alloc_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALWR) |-> op_q == OP_INSERT)
		else $error("node allocation outside insert");
	a_root_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(root_valid_q) |-> $past(state_q) == S_PRUNE && $past(op_q) == OP_DELETE)
		else $error("root released outside delete pruning");
endmodule

// ===== tb/sv/tb_fixed_height_radix_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_height_radix_tree
// Self-checking bench for the 64-way fixed-height radix tree. A behavioral
// copy of the tree (node pool, present bits, free stack) predicts every
// answer at the moment the item is accepted; a monitor compares each
// result field by field. Directed items cover empty-tree misses, duplicate
// inserts, extreme keys and values, the unknown opcode and ignored level
// writes; random phases then sweep level settings 1 to 4 under varied
// sender gaps and receiver stalls, plus a run that drains the node pool.
// ----------------------------------------------------------------------------
module tb_fixed_height_radix_tree;
	import frt_pkg::*;

	localparam int FANOUT      = 64;
	localparam int POOL        = 256;
	localparam int LEVELS_MAX  = 4;
	localparam int SETTLE      = 60;     // idle margin after the last answer
	localparam int STALL_LIMIT = 5000;   // cycles with no handshake at all

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;
	logic       cfg_we;
	logic [2:0] cfg_data;

	fixed_height_radix_tree i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// ---------------------------------------------------------------------
	// Shadow tree: same pool discipline as the block so pool exhaustion
	// lands on exactly the same item.
	// ---------------------------------------------------------------------
	logic [31:0] slot_mem [POOL*FANOUT];
	logic [63:0] used_bits [POOL];
	logic [7:0]  up_node [POOL];
	logic [5:0]  up_slot [POOL];
	logic [7:0]  free_stack [POOL];
	int          free_depth;
	bit          root_live;
	logic [7:0]  root_id;
	logic [2:0]  levels_reg;

	out_item_t   answer_q[$];   // answers still owed by the block
	logic [23:0] stored_keys[$]; // keys inserted, used to drain the tree

	int idle_pct, stall_pct;
	int errors, n_items, n_results, n_hits, n_full, quiet_cycles;

	function automatic int walk_depth();
		if (levels_reg == 3'd0) return 1;
		if (levels_reg > LEVELS_MAX) return LEVELS_MAX;
		return int'(levels_reg);
	endfunction

	function automatic int digit(logic [23:0] key, int lvl);
		return int'((key >> ((lvl - 1) * 6)) & 24'h3f);
	endfunction

	function automatic logic [7:0] grab_node();
		logic [7:0] n;
		free_depth--;
		n = free_stack[free_depth];
		used_bits[n] = '0;
		return n;
	endfunction

	function automatic void drop_node(logic [7:0] n);
		if (free_depth < POOL) begin
			free_stack[free_depth] = n;
			free_depth++;
		end
	endfunction

	// Work out the block's answer for one item and update the shadow tree.
	function automatic out_item_t tree_answer(in_item_t it);
		out_item_t  r;
		int         lv, l, d, need;
		logic [7:0] node, m, up;
		bit         path_ok;
		r = '{status: ST_NOT_FOUND, found: 1'b0, found_value: '0};
		lv = walk_depth();
		case (it.opcode)
			OP_LOOKUP, OP_DELETE: begin
				path_ok = root_live;
				node = root_id;
				for (l = lv; l > 1 && path_ok; l--) begin
					d = digit(it.key, l);
					if (!used_bits[node][d]) path_ok = 0;
					else node = slot_mem[node*FANOUT + d][7:0];
				end
				d = digit(it.key, 1);
				if (path_ok && used_bits[node][d]) begin
					r.status = ST_OK;
					if (it.opcode == OP_LOOKUP) begin
						r.found = 1'b1;
						r.found_value = slot_mem[node*FANOUT + d];
					end else begin
						used_bits[node][d] = 1'b0;
						// prune emptied nodes upward, root included
						for (int g = 0; g <= LEVELS_MAX && used_bits[node] == '0; g++) begin
							if (node == root_id) begin
								drop_node(node);
								root_live = 0;
								break;
							end
							up = up_node[node];
							used_bits[up][up_slot[node]] = 1'b0;
							drop_node(node);
							node = up;
						end
					end
				end
			end
			OP_INSERT: begin
				need = 0;
				if (!root_live) need = lv;
				else begin
					node = root_id;
					for (l = lv; l > 1; l--) begin
						d = digit(it.key, l);
						if (!used_bits[node][d]) begin
							need = l - 1;
							break;
						end
						node = slot_mem[node*FANOUT + d][7:0];
					end
				end
				if (root_live && need == 0 && used_bits[node][digit(it.key, 1)])
					r.status = ST_EXISTS;
				else if (need > free_depth)
					r.status = ST_NO_SPACE;
				else begin
					if (!root_live) begin
						root_id = grab_node();
						root_live = 1;
					end
					node = root_id;
					for (l = lv; l > 1; l--) begin
						d = digit(it.key, l);
						if (!used_bits[node][d]) begin
							m = grab_node();
							up_node[m] = node;
							up_slot[m] = d[5:0];
							slot_mem[node*FANOUT + d] = {24'd0, m};
							used_bits[node][d] = 1'b1;
						end
						node = slot_mem[node*FANOUT + d][7:0];
					end
					d = digit(it.key, 1);
					slot_mem[node*FANOUT + d] = it.value;
					used_bits[node][d] = 1'b1;
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Driving side
	// ---------------------------------------------------------------------
	// Send one item: hold valid low for random idle cycles, then present the
	// item and hold it until accepted. Predict at the accepting edge.
	task automatic send_item(input in_item_t it);
		out_item_t r;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			in_data  <= in_item_t'({$urandom, $urandom});
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		r = tree_answer(it);
		answer_q.push_back(r);
		if (it.opcode == OP_INSERT && r.status == ST_OK) stored_keys.push_back(it.key);
		n_items++;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [23:0] key,
			input logic [31:0] value);
		in_item_t it;
		it.opcode = op;
		it.key    = key;
		it.value  = value;
		send_item(it);
	endtask

	// Drop valid and wait until every owed answer is back, then idle for
	// the SETTLE margin.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answer_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write tree_levels while idle; the block ignores it with a live root.
	task automatic write_levels(input logic [2:0] v);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		if (!root_live) levels_reg = v;
		cfg_we <= 1'b0;
	endtask

	// Delete every key ever stored so the tree ends empty.
	task automatic empty_tree();
		while (stored_keys.size() != 0) send_op(OP_DELETE, stored_keys.pop_front(), $urandom);
	endtask

	// Keys mostly from a narrow digit range so paths share nodes and hit.
	function automatic logic [23:0] pick_key();
		logic [23:0] k;
		if ($urandom_range(0, 9) < 2) return 24'($urandom);
		for (int i = 0; i < 4; i++) k[i*6 +: 6] = 6'($urandom_range(0, 3));
		return k;
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	task automatic test_directed();
		send_op(OP_LOOKUP, 24'h000000, 32'hffffffff);   // empty tree miss
		send_op(OP_DELETE, 24'hffffff, 32'h0);          // empty tree delete
		send_op(OP_INSERT, 24'h000000, 32'h00000000);
		send_op(OP_INSERT, 24'h000000, 32'h12345678);   // duplicate
		send_op(OP_LOOKUP, 24'h000000, 32'h0);
		send_op(OP_INSERT, 24'hffffff, 32'hffffffff);
		send_op(OP_LOOKUP, 24'h03ffff, 32'h0);          // upper digit ignored
		send_op(OP_DELETE, 24'h03fffe, 32'h0);          // absent sibling
		send_op(2'd3, 24'hffffff, 32'hffffffff);        // unknown opcode
		write_levels(3'd1);                             // ignored: tree live
		send_op(OP_LOOKUP, 24'h000000, 32'h0);
		empty_tree();
		send_op(OP_LOOKUP, 24'hffffff, 32'h0);
		write_levels(3'd0);                             // acts as one level
		send_op(OP_INSERT, 24'hfffffe, 32'h0f0f0f0f);
		send_op(OP_LOOKUP, 24'h00003e, 32'h0);
		empty_tree();
		write_levels(3'd7);                             // acts as four levels
		send_op(OP_INSERT, 24'hffffff, 32'ha5a5a5a5);
		send_op(OP_LOOKUP, 24'hffffff, 32'h0);
		send_op(OP_LOOKUP, 24'h7fffff, 32'h0);
		empty_tree();
	endtask

	task automatic test_random(input int count, input logic [2:0] lv,
			input int idle, input int stall);
		int sel;
		write_levels(lv);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)      send_op(OP_INSERT, pick_key(), $urandom);
			else if (sel < 70) send_op(OP_LOOKUP, pick_key(), $urandom);
			else if (sel < 95) send_op(OP_DELETE, pick_key(), $urandom);
			else               send_op(2'd3, pick_key(), $urandom);
		end
		empty_tree();
	endtask

	// Spread keys over top digits so each needs fresh nodes until the pool
	// runs dry, probe some, then tear everything down.
	task automatic test_pool_exhaust();
		write_levels(3'd4);
		idle_pct  = 20;
		stall_pct = 20;
		for (int i = 0; i < 64; i++)
			for (int j = 0; j < 3; j++)
				send_op(OP_INSERT, {6'(i), 6'(j), 12'($urandom)}, $urandom);
		repeat (20) send_op(OP_LOOKUP, {6'($urandom_range(0, 63)), 18'($urandom)}, $urandom);
		empty_tree();
	endtask

	// ---------------------------------------------------------------------
	// Receiving side: stall, check, watchdog
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (answer_q.size() == 0) begin
				$error("result with nothing expected: status %0d", out_data.status);
				errors++;
			end else begin
				w = answer_q.pop_front();
				if (w.found) n_hits++;
				if (w.status == ST_NO_SPACE) n_full++;
				if (out_data.status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, out_data.status);
					errors++;
				end
				if (out_data.found !== w.found) begin
					$error("found: expected %0d, got %0d", w.found, out_data.found);
					errors++;
				end
				if (out_data.found_value !== w.found_value) begin
					$error("found_value: expected %h, got %h", w.found_value,
						out_data.found_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		arst_n = 1'b0; in_valid = 1'b0; in_data = '0;
		out_stall = 1'b0; cfg_we = 1'b0; cfg_data = 3'd0;
		idle_pct = 0; stall_pct = 0; quiet_cycles = 0;
		errors = 0; n_items = 0; n_results = 0; n_hits = 0; n_full = 0;
		foreach (used_bits[i]) used_bits[i] = '0;
		foreach (free_stack[i]) free_stack[i] = 8'(i);
		free_depth = POOL;
		root_live = 0;
		root_id = '0;
		levels_reg = 3'd3;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(350, 3'd2, 0, 0);
		test_random(350, 3'd3, 72, 0);
		test_random(350, 3'd4, 0, 72);
		test_random(350, 3'd1, 35, 35);
		test_pool_exhaust();
		drain_results();

		$display("covered %0d items, %0d results, %0d lookup hits, %0d pool-full inserts",
			n_items, n_results, n_hits, n_full);
		$display("level settings 0 to 4 and 7 exercised under mixed sender gaps and stalls");
		if (errors == 0 && answer_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
